/* rtl/gf64m_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf64m_pkg: shared types and constants of the GF(2^64) polynomial MAC
// Field widths, register indexes and control structs for the bit-serial
// multiplier and the configuration registers.
// ----------------------------------------------------------------------------
package gf64m_pkg;

  localparam int unsigned GfWidth  = 64;
  localparam int unsigned TagWidth = 32;
  localparam int unsigned LenWidth = 32;
  localparam int unsigned CntWidth = $clog2(GfWidth);
  localparam int unsigned IdxWidth = 2;

  // x^64 + x^4 + x^3 + x + 1
  localparam logic [GfWidth-1:0] GfReduction = 64'h0000_0000_0000_001b;
  localparam logic [CntWidth-1:0] CntLast    = CntWidth'(GfWidth - 1);

  typedef enum logic [IdxWidth-1:0] {
    CFG_HASH_KEY_P   = 2'd0,
    CFG_HASH_KEY_Q   = 2'd1,
    CFG_OUT_MASK     = 2'd2,
    CFG_BIT_LENGTH   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [GfWidth-1:0]  key_p;
    logic [GfWidth-1:0]  key_q;
    logic [TagWidth-1:0] out_mask;
    logic [LenWidth-1:0] bit_length;
    logic [GfWidth-1:0]  last_mask;   // bits of the last word that are kept
  } cfg_t;

  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage
`default_nettype wire

/* rtl/gf64m_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf64m_cfg: configuration registers
// Holds P, Q, the tag mask word and the bit length, and derives the mask
// applied to the last message word.
// ----------------------------------------------------------------------------
module gf64m_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 wr_en_i,
  input  wire logic [gf64m_pkg::IdxWidth-1:0]       wr_index_i,
  input  wire logic [gf64m_pkg::GfWidth-1:0]        wr_data_i,
  output gf64m_pkg::cfg_t                           cfg_o
);

  logic [gf64m_pkg::GfWidth-1:0]  key_p_q, key_p_d;
  logic [gf64m_pkg::GfWidth-1:0]  key_q_q, key_q_d;
  logic [gf64m_pkg::TagWidth-1:0] out_mask_q, out_mask_d;
  logic [gf64m_pkg::LenWidth-1:0] bit_length_q, bit_length_d;
  logic [gf64m_pkg::CntWidth-1:0] keep;

  always_comb begin
    key_p_d      = key_p_q;
    key_q_d      = key_q_q;
    out_mask_d   = out_mask_q;
    bit_length_d = bit_length_q;
    if (wr_en_i) begin
      unique case (gf64m_pkg::cfg_idx_e'(wr_index_i))
        gf64m_pkg::CFG_HASH_KEY_P: key_p_d      = wr_data_i;
        gf64m_pkg::CFG_HASH_KEY_Q: key_q_d      = wr_data_i;
        gf64m_pkg::CFG_OUT_MASK:   out_mask_d   = wr_data_i[gf64m_pkg::TagWidth-1:0];
        gf64m_pkg::CFG_BIT_LENGTH: bit_length_d = wr_data_i[gf64m_pkg::LenWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_p_q      <= '0;
      key_q_q      <= '0;
      out_mask_q   <= '0;
      bit_length_q <= gf64m_pkg::LenWidth'(1);
    end else begin
      key_p_q      <= key_p_d;
      key_q_q      <= key_q_d;
      out_mask_q   <= out_mask_d;
      bit_length_q <= bit_length_d;
    end
  end

  // keep the top (length mod 64) bits; zero keeps the whole word
  assign keep = bit_length_q[gf64m_pkg::CntWidth-1:0];

  always_comb begin
    cfg_o.key_p      = key_p_q;
    cfg_o.key_q      = key_q_q;
    cfg_o.out_mask   = out_mask_q;
    cfg_o.bit_length = bit_length_q;
    if (keep == '0) begin
      cfg_o.last_mask = '1;
    end else begin
      cfg_o.last_mask = ~({gf64m_pkg::GfWidth{1'b1}} >> keep);
    end
  end

endmodule
`default_nettype wire

/* rtl/gf64m_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf64m_mul: bit-serial GF(2^64) multiplier
// Consumes one bit of the multiplier per cycle, LSB first, while the
// multiplicand is doubled (xtime) each cycle.
// ----------------------------------------------------------------------------
module gf64m_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gf64m_pkg::mul_ctrl_t          ctrl_i,
  input  wire logic [gf64m_pkg::GfWidth-1:0] a_i,
  input  wire logic [gf64m_pkg::GfWidth-1:0] b_i,
  output gf64m_pkg::mul_stat_t               stat_o,
  output logic      [gf64m_pkg::GfWidth-1:0] prod_o
);

  logic [gf64m_pkg::GfWidth-1:0]  a_q, a_d;
  logic [gf64m_pkg::GfWidth-1:0]  b_q, b_d;
  logic [gf64m_pkg::GfWidth-1:0]  prod_q, prod_d;
  logic [gf64m_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    prod_d = prod_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      a_d    = a_i;
      b_d    = b_i;
      prod_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        prod_d = prod_q ^ a_q;
      end
      a_d = {a_q[gf64m_pkg::GfWidth-2:0], 1'b0}
            ^ (a_q[gf64m_pkg::GfWidth-1] ? gf64m_pkg::GfReduction : '0);
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == gf64m_pkg::CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = prod_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held longer than one cycle");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q) && $past(cnt_q) == gf64m_pkg::CntLast)
    else $error("multiplier done without a full bit sweep");

endmodule
`default_nettype wire

/* rtl/gf64_polynomial_mac.sv */
// Sequencing: a word without the last mark holds the block in ST_MUL_P; a last word
// runs ST_MUL_P, then ST_MUL_Q (ST_HOLD while the output stalls) until its tag is
// loaded into the output register. Words are taken only in ST_IDLE: the single
// bit-serial GF(2^64) multiplier (one multiplier bit per cycle) is shared by P and Q.
// Reset: asynchronous, active low; clears the accumulator and loads the
// register defaults (keys and mask zero, bit length one).
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf64_polynomial_mac: GF(2^64) polynomial evaluation MAC
// Folds 64-bit message words into an accumulator with multiplier P, then
// finishes with the bit length and multiplier Q into a 32-bit tag.
// ----------------------------------------------------------------------------
module gf64_polynomial_mac (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [gf64m_pkg::IdxWidth-1:0]       cfg_index_i,
  input  wire logic [gf64m_pkg::GfWidth-1:0]        cfg_data_i,
  // message words
  input  wire logic                                 message_valid_i,
  output logic                                      message_stall_o,
  input  wire logic [gf64m_pkg::GfWidth-1:0]        message_block_i,
  input  wire logic                                 last_block_i,
  // tags
  output logic                                      mac_valid_o,
  input  wire logic                                 mac_stall_i,
  output logic      [gf64m_pkg::TagWidth-1:0]       mac_value_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL_P = 4'b0010,
    ST_MUL_Q = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [gf64m_pkg::GfWidth-1:0]   acc_q, acc_d;
  logic                            last_q, last_d;
  logic                            out_valid_q, out_valid_d;
  logic [gf64m_pkg::TagWidth-1:0]  out_value_q, out_value_d;

  gf64m_pkg::cfg_t                 cfg;
  gf64m_pkg::mul_ctrl_t            mul_ctrl;
  gf64m_pkg::mul_stat_t            mul_stat;
  logic [gf64m_pkg::GfWidth-1:0]   mul_a, mul_b, mul_prod;
  logic                            in_accept;
  logic                            out_free;
  logic [gf64m_pkg::GfWidth-1:0]   block_masked;

  gf64m_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  gf64m_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .stat_o (mul_stat),
    .prod_o (mul_prod)
  );

  assign cfg_ready_o     = 1'b1;
  assign message_stall_o = (state_q != ST_IDLE);
  assign in_accept       = message_valid_i & ~message_stall_o;
  // output register can take a new tag at the next edge
  assign out_free        = ~out_valid_q | ~mac_stall_i;
  assign block_masked    = last_block_i ? (message_block_i & cfg.last_mask)
                                        : message_block_i;

  always_comb begin
    state_d       = state_q;
    acc_d         = acc_q;
    last_d        = last_q;
    out_valid_d   = out_valid_q & mac_stall_i;
    out_value_d   = out_value_q;
    mul_ctrl.start = 1'b0;
    mul_a         = acc_q ^ block_masked;
    mul_b         = cfg.key_p;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mul_ctrl.start = 1'b1;
          last_d         = last_block_i;
          state_d        = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        if (mul_stat.done) begin
          if (last_q) begin
            mul_ctrl.start = 1'b1;
            mul_a   = mul_prod ^ {{(gf64m_pkg::GfWidth-gf64m_pkg::LenWidth){1'b0}},
                                  cfg.bit_length};
            mul_b   = cfg.key_q;
            acc_d   = '0;
            state_d = ST_MUL_Q;
          end else begin
            acc_d   = mul_prod;
            state_d = ST_IDLE;
          end
        end
      end
      ST_MUL_Q: begin
        if (mul_stat.done) begin
          state_d = ST_HOLD;
          if (out_free) begin
            out_valid_d = 1'b1;
            out_value_d = mul_prod[gf64m_pkg::GfWidth-1 -: gf64m_pkg::TagWidth]
                          ^ cfg.out_mask;
            state_d     = ST_IDLE;
          end
        end
      end
      ST_HOLD: begin
        // product stays in the multiplier until the next start
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = mul_prod[gf64m_pkg::GfWidth-1 -: gf64m_pkg::TagWidth]
                        ^ cfg.out_mask;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
  end

  assign mac_valid_o = out_valid_q;
  assign mac_value_o = out_value_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_ctrl.start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_done_in_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> (state_q == ST_MUL_P || state_q == ST_MUL_Q))
    else $error("multiplier done outside a multiply state");

  a_acc_clear_for_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_Q || state_q == ST_HOLD) |-> acc_q == '0)
    else $error("accumulator not cleared during final multiply");

  a_tag_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mac_valid_o) |-> ($past(state_q) == ST_MUL_Q || $past(state_q) == ST_HOLD))
    else $error("tag appeared without a final multiply");

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the GF(2^64) polynomial MAC
// Drives message words and register writes with random gaps and stalls,
// predicts every tag in a scoreboard and compares it with the block's output.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned GfWidth  = gf64m_pkg::GfWidth;
  localparam int unsigned TagWidth = gf64m_pkg::TagWidth;
  localparam int unsigned LenWidth = gf64m_pkg::LenWidth;
  localparam int unsigned IdxWidth = gf64m_pkg::IdxWidth;

  localparam logic [GfWidth-1:0] ReductionPoly = 64'h1b;
  localparam logic [GfWidth-1:0] AllOnes       = '1;
  localparam int QuietLimit = 4000;  // cycles without any accepted word, register write or tag
  localparam int DrainWait  = 200;   // margin for the multiplier to go quiet
  localparam int HoldCycles = 800;

  // Folds accepted words into its own accumulator and queues the tag of each
  // finished message.
  class tag_scoreboard;
    logic [GfWidth-1:0]  key_p;
    logic [GfWidth-1:0]  key_q;
    logic [TagWidth-1:0] tag_mask;
    logic [LenWidth-1:0] bit_len;
    logic [GfWidth-1:0]  acc;
    logic [TagWidth-1:0] tags_due[$];
    int                  errors;

    function new();
      key_p    = '0;
      key_q    = '0;
      tag_mask = '0;
      bit_len  = 1;
      acc      = '0;
      errors   = 0;
    endfunction

    function logic [GfWidth-1:0] gf_mul(logic [GfWidth-1:0] a, logic [GfWidth-1:0] b);
      logic [GfWidth-1:0] prod;
      prod = '0;
      for (int k = 0; k < GfWidth; k++) begin
        if (b[k]) prod ^= a;
        a = a[GfWidth-1] ? ((a << 1) ^ ReductionPoly) : (a << 1);
      end
      return prod;
    endfunction

    function void write_reg(gf64m_pkg::cfg_idx_e idx, logic [GfWidth-1:0] data);
      case (idx)
        gf64m_pkg::CFG_HASH_KEY_P: key_p = data;
        gf64m_pkg::CFG_HASH_KEY_Q: key_q = data;
        gf64m_pkg::CFG_OUT_MASK:   tag_mask = data[TagWidth-1:0];
        gf64m_pkg::CFG_BIT_LENGTH: bit_len = data[LenWidth-1:0];
        default: ;
      endcase
    endfunction

    function void fold_word(logic [GfWidth-1:0] blk, logic last);
      logic [GfWidth-1:0] kept;
      logic [GfWidth-1:0] eval;
      logic [5:0]         keep;
      if (!last) begin
        acc = gf_mul(acc ^ blk, key_p);
        return;
      end
      // only the top (length mod 64) bits of the last word count
      keep = bit_len[5:0];
      kept = blk;
      if (keep != 0) kept = blk & ~(AllOnes >> keep);
      eval = gf_mul(acc ^ kept, key_p) ^ {{(GfWidth-LenWidth){1'b0}}, bit_len};
      eval = gf_mul(eval, key_q);
      tags_due.push_back(eval[GfWidth-1 -: TagWidth] ^ tag_mask);
      acc = '0;
    endfunction

    function void check_tag(logic [TagWidth-1:0] tag);
      logic [TagWidth-1:0] want;
      if (tags_due.size() == 0) begin
        $error("mac_value: expected none, actual %h", tag);
        errors++;
        return;
      end
      want = tags_due.pop_front();
      if (tag !== want) begin
        $error("mac_value: expected %h, actual %h", want, tag);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [IdxWidth-1:0] cfg_index_i     = '0;
  logic [GfWidth-1:0]  cfg_data_i      = '0;
  logic                message_valid_i = 1'b0;
  logic                message_stall_o;
  logic [GfWidth-1:0]  message_block_i = '0;
  logic                last_block_i    = 1'b0;
  logic                mac_valid_o;
  logic                mac_stall_i     = 1'b0;
  logic [TagWidth-1:0] mac_value_o;

  tag_scoreboard sb;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  gf64_polynomial_mac i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .message_valid_i(message_valid_i),
    .message_stall_o(message_stall_o),
    .message_block_i(message_block_i),
    .last_block_i   (last_block_i),
    .mac_valid_o    (mac_valid_o),
    .mac_stall_i    (mac_stall_i),
    .mac_value_o    (mac_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tag receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      mac_stall_i <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= HoldCycles;
      mac_stall_i  <= 1'b1;
    end else begin
      mac_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // check before fold: a tag leaving at the edge a last word enters is older
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (mac_valid_o && !mac_stall_i) sb.check_tag(mac_value_o);
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_reg(gf64m_pkg::cfg_idx_e'(cfg_index_i), cfg_data_i);
      end
      if (message_valid_i && !message_stall_o) sb.fold_word(message_block_i, last_block_i);
    end
  end

  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (message_valid_i && !message_stall_o) ||
        (mac_valid_o && !mac_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [GfWidth-1:0] blk, input logic last);
    message_valid_i <= 1'b1;
    message_block_i <= blk;
    last_block_i    <= last;
    do @(posedge clk_i); while (message_stall_o);
    if ($urandom_range(99) < idle_pct) begin
      message_valid_i <= 1'b0;
      // now and then a long gap so it lands deep inside a multiply
      if ($urandom_range(19) == 0) repeat ($urandom_range(140, 1)) @(posedge clk_i);
      else do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  function automatic logic [GfWidth-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return AllOnes;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_message(input int n_words);
    for (int i = 0; i < n_words; i++) send_word(pick_word(), i == n_words - 1);
  endtask

  // sender stops until every tag is out and the multiplier has gone quiet
  task automatic wait_idle();
    message_valid_i <= 1'b0;
    while (sb.tags_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input gf64m_pkg::cfg_idx_e idx,
                           input logic [GfWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // upper data bits of the 32-bit registers are random and must be dropped
  task automatic configure(input logic [GfWidth-1:0] p, input logic [GfWidth-1:0] q,
                           input logic [TagWidth-1:0] mask, input logic [LenWidth-1:0] len);
    wait_idle();
    write_reg(gf64m_pkg::CFG_HASH_KEY_P, p);
    write_reg(gf64m_pkg::CFG_HASH_KEY_Q, q);
    write_reg(gf64m_pkg::CFG_OUT_MASK, {$urandom(), mask});
    write_reg(gf64m_pkg::CFG_BIT_LENGTH, {$urandom(), len});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [LenWidth-1:0] pick_length();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 1;
      2:       return 64 * $urandom_range(8, 1);
      3:       return '1;
      4:       return $urandom_range(63, 1);
      5:       return 63;
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_msg_len();
    case ($urandom_range(9))
      0, 1, 2, 3: return 1;
      4, 5, 6, 7: return $urandom_range(4, 2);
      8:          return $urandom_range(12, 5);
      default:    return $urandom_range(24, 13);
    endcase
  endfunction

  initial begin
    int sent;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults straight after reset
    send_word(AllOnes, 1'b1);
    // zero bit length: last word kept whole, no length term
    configure(AllOnes, AllOnes, '1, '0);
    send_word(AllOnes, 1'b0);
    send_word(AllOnes, 1'b1);
    // length a multiple of 64 with identity keys
    configure(64'd1, 64'd1, '0, 64);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    send_word(64'd1, 1'b1);
    // one bit kept of the last word
    configure({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom(), 1);
    send_word('0, 1'b0);
    send_word(AllOnes, 1'b1);
    configure({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom(), 63);
    send_word(AllOnes, 1'b1);
    send_message(3);
    configure({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom(), '1);
    send_word({$urandom(), $urandom()}, 1'b0);
    send_word(AllOnes, 1'b1);
    // zero P key with a length of 65 over two words
    configure('0, {$urandom(), $urandom()}, $urandom(), 65);
    send_word({$urandom(), $urandom()}, 1'b0);
    send_word({$urandom(), $urandom()}, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      configure(($urandom_range(7) == 0) ? AllOnes : {$urandom(), $urandom()},
                ($urandom_range(7) == 0) ? '0 : {$urandom(), $urandom()},
                $urandom(), pick_length());
      case (ph % 4)
        0: begin idle_pct <= 0;  stall_pct <= 0;  end
        1: begin idle_pct <= 57; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 57; end
        default: begin idle_pct <= 27; stall_pct <= 27; end
      endcase
      // long receiver hold while single-word messages keep coming
      if (ph == 4) begin
        holds_asked <= holds_asked + 1;
        repeat (12) send_message(1);
      end
      sent = 0;
      while (sent < 85) begin
        if (ph == 5 && sent >= 40 && sent < 45) begin
          message_valid_i <= 1'b0;
          while (sb.tags_due.size() != 0) @(posedge clk_i);
        end
        begin
          int n;
          n = pick_msg_len();
          send_message(n);
          sent += n;
        end
      end
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
